// ===== rtl/amt_pkg.sv =====
// Shared types, constants and permission decode for the MMU translate block.
// No dependencies; imported by the top level and the port checker.
package amt_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MMU_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_CHECK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_PROTECT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROM_PROTECT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_BASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_ACCESS   = 3'd5;

	localparam logic [2:0] FAULT_NONE        = 3'd0;
	localparam logic [2:0] FAULT_SECTION     = 3'd1;
	localparam logic [2:0] FAULT_DOMAIN      = 3'd2;
	localparam logic [2:0] FAULT_PAGE        = 3'd3;
	localparam logic [2:0] FAULT_UNSUPPORTED = 3'd4;

	localparam logic [1:0] DESC_FAULT   = 2'd0;
	localparam logic [1:0] DESC_COARSE  = 2'd1;
	localparam logic [1:0] DESC_SECTION = 2'd2;
	localparam logic [1:0] DESC_FINE    = 2'd3;

	localparam logic [1:0] L2_FAULT = 2'd0;
	localparam logic [1:0] L2_LARGE = 2'd1;
	localparam logic [1:0] L2_SMALL = 2'd2;
	localparam logic [1:0] L2_TINY  = 2'd3;

	localparam logic [1:0] DOM_CLIENT  = 2'd1;
	localparam logic [1:0] DOM_MANAGER = 2'd3;

	localparam logic [31:0] MASK_IDENTITY  = 32'hff000000;
	localparam logic [31:0] MASK_SECTION   = 32'hfff00000;
	localparam logic [31:0] MASK_LARGE     = 32'hffff0000;
	localparam logic [31:0] MASK_LARGE_SUB = 32'hffffc000;
	localparam logic [31:0] MASK_SMALL     = 32'hfffff000;
	localparam logic [31:0] MASK_SMALL_SUB = 32'hfffffc00;

	typedef struct packed {
		logic [4:0]  mode;
		logic [31:0] tag;
		logic [31:0] mask;
		logic [31:0] base;
		logic        rd;
		logic        wr;
	} tlb_entry_t;

	// returns {read, write} for an AP field under the S and R bits
	function automatic logic [1:0] perm_bits(input logic [1:0] ap, input logic s_bit,
			input logic r_bit, input logic user);
		logic [1:0] res;
		res = 2'b00;
		case (ap)
			2'd0: begin
				if (s_bit && !r_bit) begin
					res = user ? 2'b00 : 2'b10;
				end else if (r_bit && !s_bit) begin
					res = 2'b10;
				end
			end
			2'd1: res = user ? 2'b00 : 2'b11;
			2'd2: res = user ? 2'b10 : 2'b11;
			default: res = 2'b11;
		endcase
		return res;
	endfunction

endpackage

// ===== rtl/arm_mmu_translate_with_micro_tlb_top.sv =====
// Top level of the ARM-style MMU translate block with two one-entry micro TLBs.
// Depends on amt_pkg (constants, TLB entry type, permission decode).
//
// Usage:
//   Request channel (req_valid/req_stall) carries one access: TLB select, virtual
//   address, processor mode, access size and the level-1/level-2 descriptor words.
//   Response channel (rsp_valid/rsp_stall) returns one word per request: physical
//   address, permissions, hit flag, fault code, alignment flag, fetch addresses.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while no request is in flight.
// Pipeline: an accepted word passes the input register, then the result register,
//   before rsp_valid presents it. Throughput: one word per cycle while rsp_stall
//   is low; the TLB lookup, decode and refill all sit between those two
//   registers, so a request always sees the TLB as left by the one before it.
// Stall: when rsp_stall holds a full result register, the input register still
//   takes one more word; req_stall rises only when both are full.
// Reset: arst_n clears both TLB entries to invalid, all config registers to zero
//   and both pipeline registers to empty. Config is all zero after reset.
module arm_mmu_translate_with_micro_tlb_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [amt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          mode,
	input  logic [31:0]                   virtual_address,
	input  logic [4:0]                    processor_mode,
	input  logic [1:0]                    access_size,
	input  logic [31:0]                   level1_descriptor,
	input  logic [31:0]                   level2_descriptor,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [31:0]                   physical_address,
	output logic                          read_allowed,
	output logic                          write_allowed,
	output logic                          tlb_hit,
	output logic [2:0]                    fault_code,
	output logic                          alignment_fault,
	output logic [31:0]                   level1_address,
	output logic [31:0]                   level2_address
);
	import amt_pkg::*;

	logic        mmu_enable_q, align_check_q, s_bit_q, r_bit_q;
	logic [31:0] ttb_q, dacr_q;

	logic        valid_s1;
	logic        mode_s1;
	logic [31:0] va_s1;
	logic [4:0]  pm_s1;
	logic [1:0]  size_s1;
	logic [31:0] l1_s1, l2_s1;

	logic        out_valid_q;
	logic [31:0] pa_q, l1addr_q, l2addr_q;
	logic        rd_q, wr_q, hit_q, afault_q;
	logic [2:0]  fault_q;

	logic [1:0]  tlb_valid_q;
	tlb_entry_t  tlb_q [2];

	logic        advance, take_req;

	tlb_entry_t  entry, fill_entry;
	logic        user, hit, afault, do_fill, do_inval;
	logic [1:0]  amask, dacc, ap, rw, sub;
	logic [3:0]  dom;
	logic [31:0] pa, l1addr, l2addr, fill_mask;
	logic        rd, wr, large_pg, full;
	logic [2:0]  fault;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign take_req  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmu_enable_q  <= 1'b0;
			align_check_q <= 1'b0;
			s_bit_q       <= 1'b0;
			r_bit_q       <= 1'b0;
			ttb_q         <= '0;
			dacr_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MMU_ENABLE:       mmu_enable_q  <= cfg_data[0];
				REG_ALIGN_CHECK:      align_check_q <= cfg_data[0];
				REG_SYSTEM_PROTECT:   s_bit_q       <= cfg_data[0];
				REG_ROM_PROTECT:      r_bit_q       <= cfg_data[0];
				REG_TRANSLATION_BASE: ttb_q         <= cfg_data;
				REG_DOMAIN_ACCESS:    dacr_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			mode_s1 <= mode;
			va_s1   <= virtual_address;
			pm_s1   <= processor_mode;
			size_s1 <= access_size;
			l1_s1   <= level1_descriptor;
			l2_s1   <= level2_descriptor;
		end
	end

	always_comb begin
		entry     = tlb_q[mode_s1];
		user      = (pm_s1[3:0] == 4'd0);
		amask     = (size_s1 == 2'd0) ? 2'b00 : (size_s1 == 2'd1) ? 2'b01 : 2'b11;
		afault    = align_check_q && ((va_s1[1:0] & amask) != 2'b00);
		l1addr    = mmu_enable_q ? (ttb_q | {18'd0, va_s1[31:20], 2'b00}) : '0;
		l2addr    = (mmu_enable_q && l1_s1[1:0] == DESC_COARSE)
			? {l1_s1[31:10], va_s1[19:12], 2'b00} : '0;
		hit       = tlb_valid_q[mode_s1] && entry.mode == pm_s1
			&& (va_s1 & entry.mask) == entry.tag;
		dom       = l1_s1[8:5];
		dacc      = dacr_q[{dom, 1'b0} +: 2];
		large_pg  = (l2_s1[1:0] == L2_LARGE);
		sub       = large_pg ? va_s1[15:14] : va_s1[11:10];
		full      = 1'b1;
		ap        = l1_s1[11:10];
		rw        = 2'b11;
		pa        = '0;
		rd        = 1'b0;
		wr        = 1'b0;
		fault     = FAULT_NONE;
		do_fill   = 1'b0;
		do_inval  = 1'b0;
		fill_mask = MASK_IDENTITY;

		if (hit) begin
			pa = entry.base | (va_s1 & ~entry.mask);
			rd = entry.rd;
			wr = entry.wr;
		end else if (!mmu_enable_q) begin
			pa      = va_s1;
			rd      = 1'b1;
			wr      = 1'b1;
			do_fill = 1'b1;
		end else begin
			case (l1_s1[1:0])
				DESC_FAULT: fault = FAULT_SECTION;
				DESC_FINE:  fault = FAULT_UNSUPPORTED;
				default: begin
					if (dacc != DOM_CLIENT && dacc != DOM_MANAGER) begin
						fault    = FAULT_DOMAIN;
						do_inval = 1'b1;
					end else if (l1_s1[1:0] == DESC_SECTION) begin
						if (dacc == DOM_CLIENT) begin
							rw = perm_bits(ap, s_bit_q, r_bit_q, user);
						end
						pa        = {l1_s1[31:20], va_s1[19:0]};
						{rd, wr}  = rw;
						fill_mask = MASK_SECTION;
						do_fill   = 1'b1;
					end else if (l2_s1[1:0] == L2_FAULT) begin
						fault = FAULT_PAGE;
					end else if (l2_s1[1:0] == L2_TINY) begin
						fault = FAULT_UNSUPPORTED;
					end else begin
						if (dacc == DOM_CLIENT) begin
							case (sub)
								2'd0:    ap = l2_s1[5:4];
								2'd1:    ap = l2_s1[7:6];
								2'd2:    ap = l2_s1[9:8];
								default: ap = l2_s1[11:10];
							endcase
							full = (l2_s1[5:4] == l2_s1[7:6]) && (l2_s1[7:6] == l2_s1[9:8])
								&& (l2_s1[9:8] == l2_s1[11:10]);
							rw   = perm_bits(ap, s_bit_q, r_bit_q, user);
						end
						pa = large_pg ? {l2_s1[31:16], va_s1[15:0]}
							: {l2_s1[31:12], va_s1[11:0]};
						{rd, wr}  = rw;
						fill_mask = large_pg ? (full ? MASK_LARGE : MASK_LARGE_SUB)
							: (full ? MASK_SMALL : MASK_SMALL_SUB);
						do_fill   = 1'b1;
					end
				end
			endcase
		end

		fill_entry.mode = pm_s1;
		fill_entry.mask = fill_mask;
		fill_entry.tag  = va_s1 & fill_mask;
		fill_entry.base = pa & fill_mask;
		fill_entry.rd   = rd;
		fill_entry.wr   = wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q <= 2'b00;
		end else if (valid_s1 && advance) begin
			if (do_fill) begin
				tlb_valid_q[mode_s1] <= 1'b1;
			end else if (do_inval) begin
				tlb_valid_q[mode_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && do_fill) begin
			tlb_q[mode_s1] <= fill_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pa_q     <= pa;
			rd_q     <= rd;
			wr_q     <= wr;
			hit_q    <= hit;
			fault_q  <= fault;
			afault_q <= afault;
			l1addr_q <= l1addr;
			l2addr_q <= l2addr;
		end
	end

	assign rsp_valid        = out_valid_q;
	assign physical_address = pa_q;
	assign read_allowed     = rd_q;
	assign write_allowed    = wr_q;
	assign tlb_hit          = hit_q;
	assign fault_code       = fault_q;
	assign alignment_fault  = afault_q;
	assign level1_address   = l1addr_q;
	assign level2_address   = l2addr_q;

endmodule

// ===== rtl/amt_checker.sv =====
// Port-level checker for the MMU translate top level, bound in below.
// Depends on amt_pkg for the fault codes.
module amt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] physical_address,
	input logic        read_allowed,
	input logic        write_allowed,
	input logic        tlb_hit,
	input logic [2:0]  fault_code,
	input logic [31:0] level2_address
);
	import amt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(physical_address)
			&& $stable(fault_code))
		else $error("response dropped or changed under stall");

	a_fault_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fault_code != FAULT_NONE |-> physical_address == 32'd0
			&& !read_allowed && !write_allowed && !tlb_hit)
		else $error("faulted response carries a mapping");

	a_fault_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fault_code == FAULT_NONE || fault_code == FAULT_SECTION
			|| fault_code == FAULT_DOMAIN || fault_code == FAULT_PAGE
			|| fault_code == FAULT_UNSUPPORTED)
		else $error("undefined fault code");

	a_l2_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> level2_address[1:0] == 2'b00)
		else $error("level-2 fetch address not word aligned");

endmodule

bind arm_mmu_translate_with_micro_tlb_top amt_checker u_amt_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for arm_mmu_translate_with_micro_tlb_top: directed and random translations,
// each result checked field by field against an in-bench predictor of the micro TLB.
// Depends on amt_pkg and the top level RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import amt_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [31:0] va;
		logic [4:0]  pm;
		logic [1:0]  size;
		logic [31:0] l1;
		logic [31:0] l2;
	} access_t;

	typedef struct packed {
		logic [31:0] pa;
		logic        rd;
		logic        wr;
		logic        hit;
		logic [2:0]  fault;
		logic        afault;
		logic [31:0] l1a;
		logic [31:0] l2a;
	} xlat_t;

	// {user rd, user wr, priv rd, priv wr} per row {ap, R, S}
	localparam logic [63:0] PERM_ROWS = 64'hffff_bbbb_3333_0a20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic mode = 1'b0;
	logic [31:0] virtual_address = '0;
	logic [4:0] processor_mode = '0;
	logic [1:0] access_size = '0;
	logic [31:0] level1_descriptor = '0;
	logic [31:0] level2_descriptor = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [31:0] physical_address;
	logic read_allowed;
	logic write_allowed;
	logic tlb_hit;
	logic [2:0] fault_code;
	logic alignment_fault;
	logic [31:0] level1_address;
	logic [31:0] level2_address;

	arm_mmu_translate_with_micro_tlb_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .mode(mode),
		.virtual_address(virtual_address), .processor_mode(processor_mode),
		.access_size(access_size), .level1_descriptor(level1_descriptor),
		.level2_descriptor(level2_descriptor),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .physical_address(physical_address),
		.read_allowed(read_allowed), .write_allowed(write_allowed), .tlb_hit(tlb_hit),
		.fault_code(fault_code), .alignment_fault(alignment_fault),
		.level1_address(level1_address), .level2_address(level2_address)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow configuration and micro TLB
	logic mmu_on, align_on, s_bit, r_bit;
	logic [31:0] l1_base, dom_ctl;
	logic ent_valid [2];
	logic [4:0] ent_pm [2];
	logic [31:0] ent_tag [2];
	logic [31:0] ent_mask [2];
	logic [31:0] ent_base [2];
	logic ent_rd [2];
	logic ent_wr [2];

	xlat_t awaited_xlat [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [31:0] last_va [2];

	initial begin
		mmu_on = 0; align_on = 0; s_bit = 0; r_bit = 0; l1_base = '0; dom_ctl = '0;
		for (int i = 0; i < 2; i++) begin
			ent_valid[i] = 0; ent_pm[i] = '0; ent_tag[i] = '0; ent_mask[i] = '0;
			ent_base[i] = '0; ent_rd[i] = 0; ent_wr[i] = 0; last_va[i] = '0;
		end
	end

	function automatic logic [1:0] perm_rw(logic [1:0] ap, logic user);
		logic [3:0] row;
		row = PERM_ROWS[{ap, r_bit, s_bit}*4 +: 4];
		return user ? row[3:2] : row[1:0];
	endfunction

	function automatic void load_entry(logic t, logic [31:0] va, logic [31:0] pa,
			logic [31:0] mask, logic [4:0] pm, logic rd, logic wr);
		ent_valid[t] = 1'b1;
		ent_pm[t] = pm;
		ent_mask[t] = mask;
		ent_tag[t] = va & mask;
		ent_base[t] = pa & mask;
		ent_rd[t] = rd;
		ent_wr[t] = wr;
	endfunction

	function automatic xlat_t translate_access(access_t a);
		xlat_t r;
		logic t, user, large_pg, full;
		logic [31:0] amask, mask, p;
		logic [3:0] dom;
		logic [1:0] dacc, sub;
		logic [1:0] rw;
		r = '0;
		t = a.mode;
		user = (a.pm[3:0] == 4'd0);
		amask = (a.size == 2'd0) ? 32'd0 : (a.size == 2'd1) ? 32'd1 : 32'd3;
		r.afault = align_on && ((a.va & amask) != 0);
		if (mmu_on) begin
			r.l1a = l1_base | {18'd0, a.va[31:20], 2'b00};
			if (a.l1[1:0] == DESC_COARSE)
				r.l2a = (a.l1 & 32'hfffffc00) | {22'd0, a.va[19:12], 2'b00};
		end
		if (ent_valid[t] && ent_pm[t] == a.pm && (a.va & ent_mask[t]) == ent_tag[t]) begin
			r.hit = 1'b1;
			r.pa = ent_base[t] | (a.va & ~ent_mask[t]);
			r.rd = ent_rd[t];
			r.wr = ent_wr[t];
		end else if (!mmu_on) begin
			r.pa = a.va; r.rd = 1'b1; r.wr = 1'b1;
			load_entry(t, a.va, a.va, MASK_IDENTITY, a.pm, 1'b1, 1'b1);
		end else begin
			dom = a.l1[8:5];
			dacc = dom_ctl[dom*2 +: 2];
			if (a.l1[1:0] == DESC_FAULT) begin
				r.fault = FAULT_SECTION;
			end else if (a.l1[1:0] == DESC_FINE) begin
				r.fault = FAULT_UNSUPPORTED;
			end else if (!dacc[0]) begin
				r.fault = FAULT_DOMAIN;
				ent_valid[t] = 1'b0;
			end else if (a.l1[1:0] == DESC_SECTION) begin
				p = (a.l1 & 32'hfff00000) | (a.va & 32'h000fffff);
				rw = (dacc == DOM_CLIENT) ? perm_rw(a.l1[11:10], user) : 2'b11;
				r.pa = p; r.rd = rw[1]; r.wr = rw[0];
				load_entry(t, a.va, p, MASK_SECTION, a.pm, rw[1], rw[0]);
			end else if (a.l2[1:0] == L2_FAULT) begin
				r.fault = FAULT_PAGE;
			end else if (a.l2[1:0] == L2_TINY) begin
				r.fault = FAULT_UNSUPPORTED;
			end else begin
				large_pg = (a.l2[1:0] == L2_LARGE);
				p = large_pg ? ((a.l2 & 32'hffff0000) | (a.va & 32'h0000ffff))
				             : ((a.l2 & 32'hfffff000) | (a.va & 32'h00000fff));
				sub = large_pg ? a.va[15:14] : a.va[11:10];
				full = 1'b1;
				rw = 2'b11;
				if (dacc == DOM_CLIENT) begin
					full = (a.l2[5:4] == a.l2[7:6]) && (a.l2[7:6] == a.l2[9:8])
						&& (a.l2[9:8] == a.l2[11:10]);
					rw = perm_rw(a.l2[4 + 2*sub +: 2], user);
				end
				if (large_pg) mask = full ? MASK_LARGE : MASK_LARGE_SUB;
				else mask = full ? MASK_SMALL : MASK_SMALL_SUB;
				r.pa = p; r.rd = rw[1]; r.wr = rw[0];
				load_entry(t, a.va, p, mask, a.pm, rw[1], rw[0]);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		xlat_t w;
		if (rsp_valid && !rsp_stall) begin
			if (awaited_xlat.size() == 0) begin
				report_mismatch("unexpected word", physical_address, 32'd0);
			end else begin
				w = awaited_xlat.pop_front();
				if (physical_address !== w.pa)
					report_mismatch("physical_address", physical_address, w.pa);
				if (read_allowed !== w.rd)
					report_mismatch("read_allowed", 32'(read_allowed), 32'(w.rd));
				if (write_allowed !== w.wr)
					report_mismatch("write_allowed", 32'(write_allowed), 32'(w.wr));
				if (tlb_hit !== w.hit)
					report_mismatch("tlb_hit", 32'(tlb_hit), 32'(w.hit));
				if (fault_code !== w.fault)
					report_mismatch("fault_code", 32'(fault_code), 32'(w.fault));
				if (alignment_fault !== w.afault)
					report_mismatch("alignment_fault", 32'(alignment_fault), 32'(w.afault));
				if (level1_address !== w.l1a)
					report_mismatch("level1_address", level1_address, w.l1a);
				if (level2_address !== w.l2a)
					report_mismatch("level2_address", level2_address, w.l2a);
			end
		end
	end

	task automatic send_access(access_t a);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		mode = a.mode;
		virtual_address = a.va;
		processor_mode = a.pm;
		access_size = a.size;
		level1_descriptor = a.l1;
		level2_descriptor = a.l2;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		awaited_xlat.push_back(translate_access(a));
	endtask

	task automatic wait_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (awaited_xlat.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		wait_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MMU_ENABLE: mmu_on = data[0];
			REG_ALIGN_CHECK: align_on = data[0];
			REG_SYSTEM_PROTECT: s_bit = data[0];
			REG_ROM_PROTECT: r_bit = data[0];
			REG_TRANSLATION_BASE: l1_base = data;
			REG_DOMAIN_ACCESS: dom_ctl = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic access_t mk(logic m, logic [31:0] va, logic [4:0] pm, logic [1:0] size,
			logic [31:0] l1, logic [31:0] l2);
		access_t a;
		a.mode = m; a.va = va; a.pm = pm; a.size = size; a.l1 = l1; a.l2 = l2;
		return a;
	endfunction

	function automatic access_t random_access();
		access_t a;
		int r;
		a.mode = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 40) a.pm = 5'h10;
		else if (r < 70) a.pm = 5'h13;
		else if (r < 80) a.pm = 5'h00;
		else a.pm = 5'($urandom);
		a.va = $urandom;
		r = $urandom_range(99);
		// mostly stay near the last address of this entry so that hits come often
		if (r < 30) a.va[31:12] = last_va[a.mode][31:12];
		else if (r < 50) a.va[31:20] = last_va[a.mode][31:20];
		else if (r < 60) a.va[31:24] = last_va[a.mode][31:24];
		last_va[a.mode] = a.va;
		a.size = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		a.l1 = $urandom;
		r = $urandom_range(99);
		if (r < 10) a.l1[1:0] = DESC_FAULT;
		else if (r < 20) a.l1[1:0] = DESC_FINE;
		else if (r < 55) a.l1[1:0] = DESC_SECTION;
		else a.l1[1:0] = DESC_COARSE;
		a.l2 = $urandom;
		r = $urandom_range(99);
		if (r < 8) a.l2[1:0] = L2_FAULT;
		else if (r < 16) a.l2[1:0] = L2_TINY;
		else if (r < 50) a.l2[1:0] = L2_LARGE;
		else a.l2[1:0] = L2_SMALL;
		if ($urandom_range(1)) a.l2[11:4] = {4{a.l2[5:4]}};
		return a;
	endfunction

	task automatic test_passthrough();
		send_access(mk(0, 32'h1234_5678, 5'h10, 2'd2, $urandom, $urandom));
		send_access(mk(0, 32'h12ff_ffff, 5'h10, 2'd0, $urandom, $urandom));
		send_access(mk(0, 32'h1234_5678, 5'h13, 2'd2, $urandom, $urandom));
		send_access(mk(1, 32'hffff_ffff, 5'h1f, 2'd0, $urandom, $urandom));
		send_access(mk(1, 32'h0000_0000, 5'h00, 2'd1, $urandom, $urandom));
	endtask

	task automatic test_alignment();
		write_reg(REG_ALIGN_CHECK, 32'd1);
		send_access(mk(0, 32'h1200_0001, 5'h13, 2'd1, $urandom, $urandom));
		send_access(mk(0, 32'h1200_0002, 5'h13, 2'd2, $urandom, $urandom));
		send_access(mk(0, 32'h1200_0003, 5'h13, 2'd3, $urandom, $urandom));
		send_access(mk(1, 32'h0000_0001, 5'h00, 2'd0, $urandom, $urandom));
	endtask

	task automatic test_sections();
		write_reg(REG_MMU_ENABLE, 32'd1);
		write_reg(REG_TRANSLATION_BASE, 32'h0000_4000);
		write_reg(REG_DOMAIN_ACCESS, 32'h0000_0087);
		write_reg(REG_SYSTEM_PROTECT, 32'd1);
		send_access(mk(0, 32'h4012_3456, 5'h10, 2'd2, 32'h8000_0022, 32'd0));
		send_access(mk(0, 32'h401f_fffc, 5'h10, 2'd2, 32'd0, 32'd0));
		send_access(mk(1, 32'h5000_0004, 5'h13, 2'd2, 32'habc0_0802, 32'd0));
		send_access(mk(0, 32'h6000_0000, 5'h13, 2'd0, 32'h1230_0042, 32'd0));
		send_access(mk(0, 32'h4012_3456, 5'h10, 2'd2, 32'd0, 32'd0));
		send_access(mk(0, 32'h4100_0000, 5'h13, 2'd2, 32'h8000_0022, 32'd0));
	endtask

	task automatic test_pages();
		send_access(mk(0, 32'h7001_2345, 5'h10, 2'd2, 32'h0012_3421, 32'hdead_0ff1));
		send_access(mk(1, 32'h7002_1c00, 5'h10, 2'd2, 32'h0045_6821, 32'hbeef_fe42));
		send_access(mk(1, 32'h7002_1800, 5'h10, 2'd2, 32'h0045_6821, 32'hbeef_fe42));
		send_access(mk(0, 32'h7100_0000, 5'h13, 2'd2, 32'h0000_0c21, 32'h1234_5000));
		send_access(mk(0, 32'h7200_0000, 5'h13, 2'd2, 32'h0000_0c21, 32'h1234_5003));
		send_access(mk(0, 32'h7300_0000, 5'h13, 2'd2, 32'h0000_0023, 32'd0));
		send_access(mk(0, 32'h7400_8000, 5'h13, 2'd2, 32'h0000_0001, 32'hcafe_1012));
	endtask

	task automatic test_tlb_precedence();
		write_reg(REG_MMU_ENABLE, 32'd0);
		send_access(mk(1, 32'h7002_1800, 5'h10, 2'd0, $urandom, $urandom));
		send_access(mk(1, 32'h9000_0000, 5'h10, 2'd0, $urandom, $urandom));
		write_reg(REG_ROM_PROTECT, 32'd1);
		write_reg(REG_MMU_ENABLE, 32'd1);
		send_access(mk(0, 32'h8800_0000, 5'h13, 2'd2, 32'h0880_0022, 32'd0));
		write_reg(REG_SYSTEM_PROTECT, 32'd0);
		send_access(mk(0, 32'h8900_0000, 5'h10, 2'd2, 32'h0890_0022, 32'd0));
	endtask

	task automatic test_random();
		logic [31:0] base;
		for (int blk = 0; blk < 17; blk++) begin
			if (blk < 6) begin
				send_idle_pct = 34; recv_idle_pct = 74;
			end else if (blk < 12) begin
				send_idle_pct = 74; recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			base = $urandom;
			if ($urandom_range(1)) base[13:0] = '0;
			case (blk)
				0: begin
					write_reg(REG_MMU_ENABLE, 32'd1); write_reg(REG_ALIGN_CHECK, 32'd0);
					write_reg(REG_SYSTEM_PROTECT, 32'd0); write_reg(REG_ROM_PROTECT, 32'd0);
					write_reg(REG_TRANSLATION_BASE, 32'd0);
					write_reg(REG_DOMAIN_ACCESS, 32'hffff_ffff);
				end
				1: begin
					write_reg(REG_MMU_ENABLE, 32'hffff_ffff);
					write_reg(REG_ALIGN_CHECK, 32'hffff_ffff);
					write_reg(REG_SYSTEM_PROTECT, 32'd1); write_reg(REG_ROM_PROTECT, 32'd1);
					write_reg(REG_TRANSLATION_BASE, 32'hffff_ffff);
					write_reg(REG_DOMAIN_ACCESS, 32'h5555_5555);
				end
				2: begin
					write_reg(REG_SYSTEM_PROTECT, 32'd0); write_reg(REG_ROM_PROTECT, 32'd1);
					write_reg(REG_TRANSLATION_BASE, base);
					write_reg(REG_DOMAIN_ACCESS, 32'd0);
				end
				3: begin
					write_reg(REG_MMU_ENABLE, 32'd0);
					write_reg(REG_ALIGN_CHECK, $urandom);
				end
				default: begin
					write_reg(REG_MMU_ENABLE, 32'($urandom_range(9) != 0));
					write_reg(REG_ALIGN_CHECK, $urandom);
					write_reg(REG_SYSTEM_PROTECT, $urandom);
					write_reg(REG_ROM_PROTECT, $urandom);
					write_reg(REG_TRANSLATION_BASE, base);
					write_reg(REG_DOMAIN_ACCESS, $urandom);
				end
			endcase
			for (int i = 0; i < 50; i++) begin
				send_access(random_access());
				if (blk == 8 && i == 25) wait_results();
			end
		end
	endtask

	initial begin
		send_idle_pct = 34;
		recv_idle_pct = 74;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_passthrough();
		test_alignment();
		test_sections();
		test_pages();
		test_tlb_precedence();
		test_random();
		wait_results();
		repeat (10) @(posedge clk);
		if (awaited_xlat.size() != 0)
			report_mismatch("words never returned", 32'(awaited_xlat.size()), 32'd0);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
